### rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, constants and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int ADDR_W      = 4;
  localparam int MAX_RESULTS = 13;
  localparam int PIECE_MAX   = 12;

  // register word indices, taken from paddr[3:2]
  localparam logic [1:0] REG_ESCAPE_SLASH     = 2'd0;
  localparam logic [1:0] REG_ESCAPE_HTML      = 2'd1;
  localparam logic [1:0] REG_ESCAPE_NON_ASCII = 2'd2;

  // allowed range of the next continuation byte
  localparam logic [2:0] RULE_80_BF = 3'd0;
  localparam logic [2:0] RULE_A0_BF = 3'd1;
  localparam logic [2:0] RULE_80_9F = 3'd2;
  localparam logic [2:0] RULE_90_BF = 3'd3;
  localparam logic [2:0] RULE_80_8F = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic escape_slash;
    logic escape_html;
    logic escape_non_ascii;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       first_of_string;
    logic       last_of_string;
  } item_t;

  typedef struct packed {
    logic        in_token;
    logic        failed;
    logic [20:0] code_accum;
    logic [1:0]  bytes_pending;
    logic [2:0]  second_byte_rule;
    logic [31:0] byte_offset;
    logic [31:0] sequence_start;
  } state_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [3:0]                  cnt;
    logic                        is_end;
    logic                        is_err;
    logic [31:0]                 err_off;
  } run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    hex_digit = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

  // backslash, u, four uppercase hex digits; entry 0 goes out first
  function automatic logic [5:0][7:0] hex16(input logic [15:0] v);
    logic [5:0][7:0] r;
    r[0] = CH_BSL;
    r[1] = CH_U;
    r[2] = hex_digit(v[15:12]);
    r[3] = hex_digit(v[11:8]);
    r[4] = hex_digit(v[7:4]);
    r[5] = hex_digit(v[3:0]);
    return r;
  endfunction

  function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] rule);
    logic ok;
    case (rule)
      RULE_A0_BF: ok = b inside {[8'hA0:8'hBF]};
      RULE_80_9F: ok = b inside {[8'h80:8'h9F]};
      RULE_90_BF: ok = b inside {[8'h90:8'hBF]};
      RULE_80_8F: ok = b inside {[8'h80:8'h8F]};
      default:    ok = b inside {[8'h80:8'hBF]};
    endcase
    return ok;
  endfunction

endpackage

### rtl/jse_run_builder.sv
// ----------------------------------------------------------------------------
// jse_run_builder
// Works out all token bytes caused by one item and the next decoder state.
// ----------------------------------------------------------------------------
module jse_run_builder (
  input  jse_pkg::item_t  item,
  input  jse_pkg::state_t st,
  input  jse_pkg::cfg_t   cfg,
  output jse_pkg::run_t   run,
  output jse_pkg::state_t st_next
);

  always_comb begin
    jse_pkg::state_t                             s;
    logic [jse_pkg::PIECE_MAX-1:0][7:0]          piece;
    logic [3:0]                                  pcnt;
    logic                                        perr;
    logic [31:0]                                 perr_off;
    logic                                        cerr;
    logic                                        cquote;
    logic [31:0]                                 here;
    logic [7:0]                                  b;
    logic [20:0]                                 acc;
    logic [20:0]                                 p;
    logic [15:0]                                 hi;
    logic [15:0]                                 lo;
    logic [3:0]                                  o;
    logic [3:0]                                  j;
    logic                                        has_close;
    logic [7:0]                                  close_byte;

    b        = item.in_byte;
    s        = st;
    piece    = '0;
    pcnt     = 4'd0;
    perr     = 1'b0;
    perr_off = '0;
    cerr     = 1'b0;
    cquote   = 1'b0;
    acc      = '0;
    p        = '0;
    hi       = '0;
    lo       = '0;

    if (item.first_of_string) begin
      s          = '0;
      s.in_token = 1'b1;
    end
    here = s.byte_offset;

    if (item.has_byte && s.in_token && !s.failed) begin
      s.byte_offset = s.byte_offset + 32'd1;
      if (s.bytes_pending != 2'd0) begin
        if (!jse_pkg::cont_ok(b, s.second_byte_rule)) begin
          perr     = 1'b1;
          perr_off = s.sequence_start;
        end else begin
          acc                = {s.code_accum[14:0], b[5:0]};
          s.code_accum       = acc;
          s.second_byte_rule = jse_pkg::RULE_80_BF;
          s.bytes_pending    = s.bytes_pending - 2'd1;
          if (!cfg.escape_non_ascii) begin
            piece[0] = b;
            pcnt     = 4'd1;
          end else if (s.bytes_pending == 2'd0) begin
            if (acc <= 21'h00FFFF) begin
              piece[5:0] = jse_pkg::hex16(acc[15:0]);
              pcnt       = 4'd6;
            end else begin
              // surrogate pair
              p           = acc - 21'h010000;
              hi          = 16'hD800 + {6'd0, p[19:10]};
              lo          = 16'hDC00 + {6'd0, p[9:0]};
              piece[5:0]  = jse_pkg::hex16(hi);
              piece[11:6] = jse_pkg::hex16(lo);
              pcnt        = 4'd12;
            end
          end
        end
      end else if (!b[7]) begin
        if (b == jse_pkg::CH_QUOTE || b == jse_pkg::CH_BSL ||
            (b == 8'h2F && cfg.escape_slash)) begin
          piece[0] = jse_pkg::CH_BSL;
          piece[1] = b;
          pcnt     = 4'd2;
        end else if ((b == 8'h3C || b == 8'h3E || b == 8'h26) && cfg.escape_html) begin
          piece[5:0] = jse_pkg::hex16({8'd0, b});
          pcnt       = 4'd6;
        end else if (b < 8'h20) begin
          piece[0] = jse_pkg::CH_BSL;
          pcnt     = 4'd2;
          case (b)
            8'h08:   piece[1] = 8'h62;
            8'h0C:   piece[1] = 8'h66;
            8'h0A:   piece[1] = 8'h6E;
            8'h0D:   piece[1] = 8'h72;
            8'h09:   piece[1] = 8'h74;
            default: begin
              piece[5:0] = jse_pkg::hex16({8'd0, b});
              pcnt       = 4'd6;
            end
          endcase
        end else begin
          piece[0] = b;
          pcnt     = 4'd1;
        end
      end else begin
        s.sequence_start   = here;
        s.second_byte_rule = jse_pkg::RULE_80_BF;
        case (b) inside
          [8'hC2:8'hDF]: begin
            s.code_accum    = {16'd0, b[4:0]};
            s.bytes_pending = 2'd1;
          end
          [8'hE0:8'hEF]: begin
            s.code_accum    = {17'd0, b[3:0]};
            s.bytes_pending = 2'd2;
            if (b == 8'hE0) s.second_byte_rule = jse_pkg::RULE_A0_BF;
            else if (b == 8'hED) s.second_byte_rule = jse_pkg::RULE_80_9F;
          end
          [8'hF0:8'hF4]: begin
            s.code_accum    = {18'd0, b[2:0]};
            s.bytes_pending = 2'd3;
            if (b == 8'hF0) s.second_byte_rule = jse_pkg::RULE_90_BF;
            else if (b == 8'hF4) s.second_byte_rule = jse_pkg::RULE_80_8F;
          end
          default: begin
            perr     = 1'b1;
            perr_off = here;
          end
        endcase
        if (!perr && !cfg.escape_non_ascii) begin
          piece[0] = b;
          pcnt     = 4'd1;
        end
      end
    end

    if (perr) begin
      s.failed           = 1'b1;
      s.in_token         = 1'b0;
      s.bytes_pending    = 2'd0;
      s.second_byte_rule = jse_pkg::RULE_80_BF;
      s.code_accum       = '0;
    end

    if (item.last_of_string && s.in_token && !s.failed) begin
      if (s.bytes_pending != 2'd0) begin
        // string ended inside a multi-byte sequence
        cerr               = 1'b1;
        perr_off           = s.sequence_start;
        s.failed           = 1'b1;
        s.in_token         = 1'b0;
        s.bytes_pending    = 2'd0;
        s.second_byte_rule = jse_pkg::RULE_80_BF;
        s.code_accum       = '0;
      end else begin
        cquote     = 1'b1;
        s.in_token = 1'b0;
      end
    end

    o          = item.first_of_string ? 4'd1 : 4'd0;
    has_close  = perr | cerr | cquote;
    close_byte = cquote ? jse_pkg::CH_QUOTE : 8'h00;

    for (int i = 0; i < jse_pkg::MAX_RESULTS; i++) begin
      j = 4'(i) - o;
      if (4'(i) < o) run.bytes[i] = jse_pkg::CH_QUOTE;
      else if (4'(i) < o + pcnt) run.bytes[i] = piece[j];
      else run.bytes[i] = close_byte;
    end
    run.cnt     = o + pcnt + {3'd0, has_close};
    run.is_end  = has_close;
    run.is_err  = perr | cerr;
    run.err_off = (perr | cerr) ? perr_off : 32'd0;
    st_next     = s;
  end

endmodule

### rtl/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// Streams the bytes of a UTF-8 string out as a quoted, escaped JSON token.
// ----------------------------------------------------------------------------
// path: the input register holds an accepted beat until its run is loaded into the result register
// throughput: one input beat per cycle while each item gives at most one byte
//   and the output is not stalled; an item giving several result beats (up to
//   13) holds the output register until all are taken, the input register takes the next beat meanwhile
// reset: synchronous, clears decoder state, options and both pipeline stages
module json_string_escaper (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       has_byte,
  input  logic                       first_of_string,
  input  logic                       last_of_string,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       last_of_run,
  output logic                       end_of_token,
  output logic                       status,
  output logic [31:0]                error_offset,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  jse_pkg::cfg_t   cfg;
  jse_pkg::item_t  in_q;
  logic            in_held;
  jse_pkg::state_t st;
  jse_pkg::state_t st_next;
  jse_pkg::run_t   run_new;

  logic [jse_pkg::MAX_RESULTS-1:0][7:0] run_bytes;
  logic [3:0]                           run_cnt;
  logic                                 run_end;
  logic                                 run_err;
  logic [31:0]                          run_off;
  logic [3:0]                           idx;
  logic                                 busy;

  logic at_last;
  logic run_free;
  logic move;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      jse_pkg::REG_ESCAPE_SLASH:     prdata = {31'd0, cfg.escape_slash};
      jse_pkg::REG_ESCAPE_HTML:      prdata = {31'd0, cfg.escape_html};
      jse_pkg::REG_ESCAPE_NON_ASCII: prdata = {31'd0, cfg.escape_non_ascii};
      default:                       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        jse_pkg::REG_ESCAPE_SLASH:     cfg.escape_slash     <= pwdata[0];
        jse_pkg::REG_ESCAPE_HTML:      cfg.escape_html      <= pwdata[0];
        jse_pkg::REG_ESCAPE_NON_ASCII: cfg.escape_non_ascii <= pwdata[0];
        default: ;
      endcase
    end
  end

  jse_run_builder u_builder (
    .item    (in_q),
    .st      (st),
    .cfg     (cfg),
    .run     (run_new),
    .st_next (st_next)
  );

  assign at_last  = (idx == run_cnt - 4'd1);
  assign run_free = !busy || (out_ready && at_last);
  assign move     = in_held && run_free;
  assign in_ready = !in_held || move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else begin
      in_held <= (in_valid && in_ready) || (in_held && !move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.in_byte         <= in_byte;
      in_q.has_byte        <= has_byte;
      in_q.first_of_string <= first_of_string;
      in_q.last_of_string  <= last_of_string;
    end
  end

  // decoder state advances when the held item moves into the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (move) begin
      st <= st_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (move && run_new.cnt != 4'd0) begin
      busy <= 1'b1;
      idx  <= 4'd0;
    end else if (busy && out_ready) begin
      if (at_last) busy <= 1'b0;
      else idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && run_new.cnt != 4'd0) begin
      run_bytes <= run_new.bytes;
      run_cnt   <= run_new.cnt;
      run_end   <= run_new.is_end;
      run_err   <= run_new.is_err;
      run_off   <= run_new.err_off;
    end
  end

  assign out_valid    = busy;
  assign out_byte     = run_bytes[idx];
  assign last_of_run  = at_last;
  assign end_of_token = at_last && run_end;
  assign status       = at_last && run_err;
  assign error_offset = (at_last && run_err) ? run_off : 32'd0;

endmodule

### rtl/jse_checker.sv
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks on the escaper's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        last_of_run,
  input logic        end_of_token,
  input logic        status,
  input logic [31:0] error_offset
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run)
      && $stable(end_of_token) && $stable(status) && $stable(error_offset))
    else $error("result beat changed while stalled");

  // an error beat closes the token and its run
  a_err_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> end_of_token && last_of_run && out_byte == 8'h00)
    else $error("error beat not closing token");

  // end of token is always the last beat of a run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_token |-> last_of_run)
    else $error("end of token before end of run");

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> error_offset == 32'd0)
    else $error("offset set on good beat");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for json_string_escaper. Strings are streamed in byte by
// byte. A behavioral escaper computes the token beats each input beat should
// produce, and every output beat is checked against them in order. Directed
// strings cover the escape rules and the UTF-8 error cases. Random strings
// follow, mostly well-formed UTF-8 with some corruption, under several option
// settings, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_seq_t[$];

  typedef enum logic [1:0] {
    END_ON_BYTE,   // last_of_string rides on the final byte
    END_SEPARATE,  // an extra beat with no byte closes the string
    END_NONE       // string is left open, the next start abandons it
  } str_end_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        run_end;
    logic        tok_end;
    logic        bad;
    logic [31:0] off;
  } beat_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [0:15][7:0] HEX_CHARS = "0123456789ABCDEF";
  localparam logic [0:14][7:0] SPECIAL_CHARS = {
    jse_pkg::CH_QUOTE, jse_pkg::CH_BSL, CH_SLASH, CH_LT, CH_GT, CH_AMP, 8'h00, 8'h08,
    8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h1F, CH_SPACE, 8'h7F
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        first_of_string = 1'b0;
  logic        last_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        end_of_token;
  logic        status;
  logic [31:0] error_offset;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [jse_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  json_string_escaper u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .has_byte        (has_byte),
    .first_of_string (first_of_string),
    .last_of_string  (last_of_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_of_run     (last_of_run),
    .end_of_token    (end_of_token),
    .status          (status),
    .error_offset    (error_offset),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // escaper state as the block should hold it
  jse_pkg::cfg_t opts = '0;
  logic        in_tok = 1'b0;
  logic        str_failed = 1'b0;
  logic [20:0] cp_accum = '0;
  logic [1:0]  cont_left = '0;
  logic [2:0]  cont_rule = jse_pkg::RULE_80_BF;
  logic [31:0] str_offset = '0;
  logic [31:0] seq_start = '0;

  beat_t run_beats[$];
  beat_t token_beats[$];
  int    n_errors = 0;
  int    items_sent = 0;
  bit    idle_on = 1'b0;
  int    stall_left = 0;

  function automatic void add_beat(logic [7:0] ch, logic tok_end = 1'b0, logic bad = 1'b0,
                                   logic [31:0] off = '0);
    beat_t b;
    b = '{ch: ch, run_end: 1'b0, tok_end: tok_end, bad: bad, off: off};
    if (run_beats.size() < jse_pkg::MAX_RESULTS) run_beats.push_back(b);
  endfunction

  function automatic void add_hex16(logic [15:0] v);
    add_beat(jse_pkg::CH_BSL);
    add_beat(jse_pkg::CH_U);
    add_beat(HEX_CHARS[v[15:12]]);
    add_beat(HEX_CHARS[v[11:8]]);
    add_beat(HEX_CHARS[v[7:4]]);
    add_beat(HEX_CHARS[v[3:0]]);
  endfunction

  function automatic void fail_string(logic [31:0] off);
    add_beat(8'h00, 1'b1, 1'b1, off);
    str_failed = 1'b1;
    in_tok = 1'b0;
    cont_left = '0;
    cont_rule = jse_pkg::RULE_80_BF;
    cp_accum = '0;
  endfunction

  function automatic void add_ascii(logic [7:0] b);
    logic [7:0] short_esc;
    if (b == jse_pkg::CH_QUOTE || b == jse_pkg::CH_BSL ||
        (b == CH_SLASH && opts.escape_slash)) begin
      add_beat(jse_pkg::CH_BSL);
      add_beat(b);
    end else if ((b == CH_LT || b == CH_GT || b == CH_AMP) && opts.escape_html) begin
      add_hex16({8'h00, b});
    end else if (b < CH_SPACE) begin
      case (b)
        8'h08:   short_esc = "b";
        8'h0C:   short_esc = "f";
        8'h0A:   short_esc = "n";
        8'h0D:   short_esc = "r";
        8'h09:   short_esc = "t";
        default: short_esc = 8'h00;
      endcase
      if (short_esc != 8'h00) begin
        add_beat(jse_pkg::CH_BSL);
        add_beat(short_esc);
      end else begin
        add_hex16({8'h00, b});
      end
    end else begin
      add_beat(b);
    end
  endfunction

  function automatic logic cont_byte_ok(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    case (cont_rule)
      jse_pkg::RULE_A0_BF: lo = 8'hA0;
      jse_pkg::RULE_80_9F: hi = 8'h9F;
      jse_pkg::RULE_90_BF: lo = 8'h90;
      jse_pkg::RULE_80_8F: hi = 8'h8F;
      default:    ;
    endcase
    return b >= lo && b <= hi;
  endfunction

  function automatic void take_char(logic [7:0] b);
    logic [31:0] here;
    logic [20:0] p;
    here = str_offset;
    str_offset = str_offset + 32'd1;
    if (cont_left != 0) begin
      // a bad continuation is reported at the lead byte
      if (!cont_byte_ok(b)) begin
        fail_string(seq_start);
        return;
      end
      cont_rule = jse_pkg::RULE_80_BF;
      cp_accum = {cp_accum[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (!opts.escape_non_ascii) begin
        add_beat(b);
      end else if (cont_left == 0) begin
        if (cp_accum <= 21'h00FFFF) begin
          add_hex16(cp_accum[15:0]);
        end else begin
          p = cp_accum - 21'h010000;
          add_hex16(16'hD800 | {6'd0, p[19:10]});
          add_hex16(16'hDC00 | {6'd0, p[9:0]});
        end
      end
      return;
    end
    if (b < 8'h80) begin
      add_ascii(b);
      return;
    end
    seq_start = here;
    cont_rule = jse_pkg::RULE_80_BF;
    if (b >= 8'hC2 && b <= 8'hDF) begin
      cp_accum = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      cp_accum = {17'd0, b[3:0]};
      cont_left = 2'd2;
      if (b == 8'hE0) cont_rule = jse_pkg::RULE_A0_BF;
      else if (b == 8'hED) cont_rule = jse_pkg::RULE_80_9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      cp_accum = {18'd0, b[2:0]};
      cont_left = 2'd3;
      if (b == 8'hF0) cont_rule = jse_pkg::RULE_90_BF;
      else if (b == 8'hF4) cont_rule = jse_pkg::RULE_80_8F;
    end else begin
      fail_string(here);
      return;
    end
    if (!opts.escape_non_ascii) add_beat(b);
  endfunction

  function automatic void escape_item(jse_pkg::item_t it);
    run_beats.delete();
    if (it.first_of_string) begin
      in_tok = 1'b1;
      str_failed = 1'b0;
      cp_accum = '0;
      cont_left = '0;
      cont_rule = jse_pkg::RULE_80_BF;
      str_offset = '0;
      seq_start = '0;
      add_beat(jse_pkg::CH_QUOTE);
    end
    if (it.has_byte && in_tok && !str_failed) take_char(it.in_byte);
    if (it.last_of_string && in_tok && !str_failed) begin
      if (cont_left != 0) begin
        fail_string(seq_start);
      end else begin
        add_beat(jse_pkg::CH_QUOTE, 1'b1);
        in_tok = 1'b0;
      end
    end
    if (run_beats.size() != 0) begin
      run_beats[run_beats.size() - 1].run_end = 1'b1;
      foreach (run_beats[i]) token_beats.push_back(run_beats[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // output side: compare every accepted beat with the oldest expected one
  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (token_beats.size() == 0) begin
        $error("unexpected beat: out_byte %0h status %0b", out_byte, status);
        n_errors++;
      end else begin
        want = token_beats.pop_front();
        // byte carries nothing on an error beat
        if (!want.bad) check_field("out_byte", {24'd0, want.ch}, {24'd0, out_byte});
        check_field("last_of_run", {31'd0, want.run_end}, {31'd0, last_of_run});
        check_field("end_of_token", {31'd0, want.tok_end}, {31'd0, end_of_token});
        check_field("status", {31'd0, want.bad}, {31'd0, status});
        check_field("error_offset", want.off, error_offset);
      end
    end
  end

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(logic [7:0] b, logic has, logic first, logic last);
    jse_pkg::item_t it;
    it = '{in_byte: b, has_byte: has, first_of_string: first, last_of_string: last};
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= it.in_byte;
    has_byte <= it.has_byte;
    first_of_string <= it.first_of_string;
    last_of_string <= it.last_of_string;
    do @(posedge clk); while (!in_ready);
    escape_item(it);
    items_sent++;
  endtask

  task automatic send_string(byte_seq_t s, str_end_t how, bit fill);
    for (int i = 0; i < s.size(); i++) begin
      // beats with no byte in the middle of a string change nothing
      if (fill && i != 0 && $urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, 1'b0);
      send_item(s[i], 1'b1, i == 0, how == END_ON_BYTE && i == s.size() - 1);
    end
    if (how == END_SEPARATE) send_item(8'($urandom), 1'b0, 1'b0, 1'b1);
  endtask

  // the block may still hold beats that give no result, so pause after draining
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (token_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      jse_pkg::REG_ESCAPE_SLASH:     opts.escape_slash = val;
      jse_pkg::REG_ESCAPE_HTML:      opts.escape_html = val;
      jse_pkg::REG_ESCAPE_NON_ASCII: opts.escape_non_ascii = val;
      default:              ;
    endcase
  endtask

  task automatic set_options(logic slash, logic html, logic non_ascii);
    wait_idle();
    write_reg(jse_pkg::REG_ESCAPE_SLASH, slash);
    write_reg(jse_pkg::REG_ESCAPE_HTML, html);
    write_reg(jse_pkg::REG_ESCAPE_NON_ASCII, non_ascii);
  endtask

  function automatic logic [7:0] byte_in(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic byte_seq_t code_point_bytes();
    byte_seq_t cp;
    logic [7:0] lead;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      cp.push_back(byte_in(8'h00, 8'h7F));
    end else if (kind < 5) begin
      cp.push_back(SPECIAL_CHARS[$urandom_range(0, 14)]);
    end else if (kind < 7) begin
      cp.push_back(byte_in(8'hC2, 8'hDF));
      cp.push_back(byte_in(8'h80, 8'hBF));
    end else if (kind < 9) begin
      lead = byte_in(8'hE0, 8'hEF);
      cp.push_back(lead);
      if (lead == 8'hE0) cp.push_back(byte_in(8'hA0, 8'hBF));
      else if (lead == 8'hED) cp.push_back(byte_in(8'h80, 8'h9F));
      else cp.push_back(byte_in(8'h80, 8'hBF));
      cp.push_back(byte_in(8'h80, 8'hBF));
    end else begin
      lead = byte_in(8'hF0, 8'hF4);
      cp.push_back(lead);
      if (lead == 8'hF0) cp.push_back(byte_in(8'h90, 8'hBF));
      else if (lead == 8'hF4) cp.push_back(byte_in(8'h80, 8'h8F));
      else cp.push_back(byte_in(8'h80, 8'hBF));
      cp.push_back(byte_in(8'h80, 8'hBF));
      cp.push_back(byte_in(8'h80, 8'hBF));
    end
    return cp;
  endfunction

  // mostly valid utf-8, now and then a clobbered or truncated byte
  function automatic byte_seq_t random_text();
    byte_seq_t s;
    int want_len;
    want_len = $urandom_range(1, 8);
    while (s.size() < want_len) s = {s, code_point_bytes()};
    if ($urandom_range(0, 4) == 0) s[$urandom_range(0, s.size() - 1)] = byte_in(0, 255);
    if ($urandom_range(0, 9) == 0 && s.size() > 1) void'(s.pop_back());
    return s;
  endfunction

  task automatic test_plain_escapes();
    byte_seq_t s;
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    s = {8'h00, jse_pkg::CH_QUOTE, jse_pkg::CH_BSL, CH_SLASH, 8'h08, 8'h7F};
    send_string(s, END_ON_BYTE, 1'b0);
    send_item(8'h41, 1'b1, 1'b0, 1'b0);
    s = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3, 8'hBF};
    send_string(s, END_ON_BYTE, 1'b0);
  endtask

  task automatic test_option_escapes();
    byte_seq_t s;
    set_options(1'b1, 1'b1, 1'b1);
    // top code point needs a surrogate pair, the longest run there is
    s = {CH_SLASH, CH_LT, CH_AMP, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string(s, END_ON_BYTE, 1'b0);
  endtask

  task automatic test_bad_utf8();
    byte_seq_t s;
    set_options(1'b0, 1'b0, 1'b0);
    s = {8'h61, 8'hED, 8'hA0};
    send_string(s, END_ON_BYTE, 1'b0);
    send_item(8'h62, 1'b1, 1'b0, 1'b1);
    s = {8'hC3};
    send_string(s, END_NONE, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    s = {8'hE2, 8'h82};
    send_string(s, END_ON_BYTE, 1'b0);
  endtask

  task automatic test_random_strings(logic slash, logic html, logic non_ascii, int n_items,
                                     bit with_idle);
    byte_seq_t s;
    int stop_at;
    int pick;
    str_end_t how;
    set_options(slash, html, non_ascii);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(8'($urandom), 1'b0, 1'b1, 1'b1);
      end else if (pick < 6) begin
        send_item(8'($urandom), 1'b0, 1'b1, 1'b0);
        send_item(8'($urandom), 1'b0, 1'b0, 1'b1);
      end else begin
        if (pick < 12) send_item(8'($urandom), 1'b1, 1'b0, 1'($urandom));
        s = random_text();
        pick = $urandom_range(0, 99);
        how = pick < 80 ? END_ON_BYTE : (pick < 92 ? END_SEPARATE : END_NONE);
        send_string(s, how, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_plain_escapes();
    test_option_escapes();
    test_bad_utf8();
    test_random_strings(1'b1, 1'b1, 1'b1, 70, 1'b1);
    test_random_strings(1'b0, 1'b0, 1'b0, 70, 1'b1);
    test_random_strings(1'b1, 1'b0, 1'b1, 70, 1'b1);
    test_random_strings(1'b0, 1'b1, 1'b0, 70, 1'b1);
    test_random_strings(1'($urandom), 1'($urandom), 1'($urandom), 60, 1'b1);
    test_random_strings(1'b0, 1'b1, 1'b1, 60, 1'b0);
    idle_on = 1'b0;
    wait_idle();
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
